// File: hdl/iol_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the indexed ordered list.
// No dependencies; used by iol_cell and indexed_ordered_list.
package iol_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 13;

  // Action codes on action_i
  localparam logic [ACTION_W-1:0] ACT_READ     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_INS_AT   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd4;

  // Status codes on status_o
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] RD_NONE = '1;

  // Operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_READ,
    KIND_INS,
    KIND_DEL
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// File: hdl/iol_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list row: holds the entry at a fixed position.
// Depends on iol_pkg for the command struct.
module iol_cell #(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  logic                        clk_i,
  input  iol_pkg::cmd_t               cmd_i,
  input  logic [IDX_W-1:0]            idx_i,
  input  logic [iol_pkg::DATA_W-1:0]  left_i,
  input  logic [iol_pkg::DATA_W-1:0]  right_i,
  output logic [iol_pkg::DATA_W-1:0]  entry_o,
  output logic [iol_pkg::DATA_W-1:0]  rd_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [iol_pkg::DATA_W-1:0] entry_q, entry_d;

  // Insert shifts up from the left neighbor, delete pulls from the right
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.kind)
      iol_pkg::KIND_INS: begin
        if (MY_IDX == idx_i) begin
          entry_d = cmd_i.value;
        end else if (MY_IDX > idx_i) begin
          entry_d = left_i;
        end
      end
      iol_pkg::KIND_DEL: begin
        if (MY_IDX >= idx_i) begin
          entry_d = right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

  // Read contribution, zero unless this cell is addressed
  assign rd_o = ((cmd_i.kind == iol_pkg::KIND_READ) && (MY_IDX == idx_i)) ? entry_q : '0;

endmodule

// File: hdl/indexed_ordered_list.sv
`timescale 1ns / 1ps
// Indexed ordered list top level: decode stage, row of iol_cell, result register.
// Depends on iol_pkg and iol_cell.

// The list holds up to CAPACITY signed 32-bit values in a row of cells, one
// per position. A command is taken when start is high and busy is low;
// its single result appears on the result ports with done_o high for exactly
// one cycle, after the command and result registers, and cannot be held off.
// Each command is first decoded and range-checked into the command register,
// then the whole cell row shifts (insert or delete) or returns the addressed
// entry. busy is high in the cycle after each transfer, so no new command is
// taken while the last one is in the command register. Reads out of range
// give -1; count_o always shows the number of entries after the last command.
module indexed_ordered_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [iol_pkg::ACTION_W-1:0]  action_i,
  input  logic signed [iol_pkg::POS_W-1:0] position_i,
  input  logic signed [iol_pkg::DATA_W-1:0] value_i,
  output logic                          done_o,
  output logic signed [iol_pkg::DATA_W-1:0] read_value_o,
  output logic [iol_pkg::STATUS_W-1:0]  status_o,
  output logic [iol_pkg::COUNT_W-1:0]   count_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic                         op_valid_q;
  iol_pkg::cmd_t                cmd_q, cmd_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [iol_pkg::STATUS_W-1:0] op_status_q, op_status_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         done_q;
  logic [iol_pkg::DATA_W-1:0]   rdval_q;
  logic [iol_pkg::STATUS_W-1:0] status_q;

  logic                         accept;
  logic                         pos_neg;
  logic [iol_pkg::POS_W-1:0]    pos_u;
  logic [iol_pkg::POS_W-1:0]    cnt_ext;
  logic                         rd_ok, ins_over, full;

  assign accept  = start && !op_valid_q;
  assign busy    = op_valid_q;
  assign pos_neg = position_i[iol_pkg::POS_W-1];
  assign pos_u   = $unsigned(position_i);
  assign cnt_ext = iol_pkg::POS_W'(count_q);
  assign rd_ok   = !pos_neg && (pos_u < cnt_ext);
  assign ins_over = !pos_neg && (pos_u > cnt_ext);
  assign full    = (count_q == CNT_FULL);

  // Decode and range-check the incoming command
  always_comb begin
    cmd_d.kind  = iol_pkg::KIND_NONE;
    cmd_d.value = value_i;
    idx_d       = '0;
    op_status_d = iol_pkg::ST_DONE;
    unique case (action_i)
      iol_pkg::ACT_READ: begin
        if (rd_ok) begin
          cmd_d.kind = iol_pkg::KIND_READ;
          idx_d      = IDX_W'(pos_u);
        end else begin
          op_status_d = iol_pkg::ST_RANGE;
        end
      end
      iol_pkg::ACT_INS_HEAD: begin
        if (full) begin
          op_status_d = iol_pkg::ST_FULL;
        end else begin
          cmd_d.kind = iol_pkg::KIND_INS;
        end
      end
      iol_pkg::ACT_APPEND: begin
        if (full) begin
          op_status_d = iol_pkg::ST_FULL;
        end else begin
          cmd_d.kind = iol_pkg::KIND_INS;
          idx_d      = IDX_W'(count_q);
        end
      end
      iol_pkg::ACT_INS_AT: begin
        if (ins_over) begin
          op_status_d = iol_pkg::ST_RANGE;
        end else if (full) begin
          op_status_d = iol_pkg::ST_FULL;
        end else begin
          cmd_d.kind = iol_pkg::KIND_INS;
          idx_d      = pos_neg ? '0 : IDX_W'(pos_u);
        end
      end
      iol_pkg::ACT_DELETE: begin
        if (rd_ok) begin
          cmd_d.kind = iol_pkg::KIND_DEL;
          idx_d      = IDX_W'(pos_u);
        end else begin
          op_status_d = iol_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  // Command register; an idle cycle carries a no-op to the cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
      cmd_q      <= '{kind: iol_pkg::KIND_NONE, value: '0};
    end else begin
      op_valid_q <= accept;
      cmd_q.kind <= accept ? cmd_d.kind : iol_pkg::KIND_NONE;
      if (accept) begin
        cmd_q.value <= cmd_d.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q       <= idx_d;
      op_status_q <= op_status_d;
    end
  end

  // Row of cells, each linked to both neighbors
  logic [iol_pkg::DATA_W-1:0] entry [CAPACITY];
  logic [iol_pkg::DATA_W-1:0] cell_rd [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [iol_pkg::DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cmd_q.value;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cmd_q.value;
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    iol_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_q),
      .idx_i   (idx_q),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Collect the addressed entry (only one cell drives nonzero)
  logic [iol_pkg::DATA_W-1:0] rd_or;
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // Entry count follows the shift
  always_comb begin
    count_d = count_q;
    case (cmd_q.kind)
      iol_pkg::KIND_INS: count_d = count_q + CNT_W'(1);
      iol_pkg::KIND_DEL: count_d = count_q - CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= op_valid_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (op_valid_q) begin
      rdval_q  <= (cmd_q.kind == iol_pkg::KIND_READ) ? rd_or : iol_pkg::RD_NONE;
      status_q <= op_status_q;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = $signed(rdval_q);
  assign status_o     = status_q;
  assign count_o      = iol_pkg::COUNT_W'(count_q);

endmodule

// File: verif/tb_indexed_ordered_list.sv
`timescale 1ns / 1ps
// Self-checking bench for indexed_ordered_list: directed tables, a fill, then random actions.
// Depends on iol_pkg and indexed_ordered_list; checked against table rows or a list model.
module tb_indexed_ordered_list;

  localparam int unsigned CAPACITY       = 64;
  localparam int unsigned NUM_RANDOM     = 660;
  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned DRAIN_CYCLES   = 8;

  // Action codes the block treats as no-ops
  localparam logic [iol_pkg::ACTION_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [iol_pkg::ACTION_W-1:0] ACT_RSVD7 = 3'd7;

  typedef struct packed {
    logic signed [iol_pkg::DATA_W-1:0] rd;
    logic [iol_pkg::STATUS_W-1:0]      st;
    logic [iol_pkg::COUNT_W-1:0]       cnt;
  } reply_t;

  // typed = 1: the reply in the row is the expectation; otherwise the list model gives it
  typedef struct packed {
    logic [iol_pkg::ACTION_W-1:0]      act;
    logic signed [iol_pkg::POS_W-1:0]  pos;
    logic signed [iol_pkg::DATA_W-1:0] val;
    logic                              typed;
    reply_t                            reply;
  } step_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [iol_pkg::ACTION_W-1:0]      action_i = '0;
  logic signed [iol_pkg::POS_W-1:0]  position_i = '0;
  logic signed [iol_pkg::DATA_W-1:0] value_i = '0;
  logic                              done_o;
  logic signed [iol_pkg::DATA_W-1:0] read_value_o;
  logic [iol_pkg::STATUS_W-1:0]      status_o;
  logic [iol_pkg::COUNT_W-1:0]       count_o;

  // List model state and the replies still owed by the block
  logic signed [iol_pkg::DATA_W-1:0] list_words [CAPACITY];
  int unsigned                       list_len = 0;
  reply_t                            awaited_q [$];
  int unsigned                       mismatches = 0;
  int unsigned                       idle_cycles = 0;
  bit                                steady_feed = 1'b0;

  // Empty list first, then a few entries: range checks, clamping, extremes, no-op codes
  step_row_t opening_rows [19] = '{
    '{iol_pkg::ACT_READ,     16'sd0,    32'sd0,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd0}},
    '{iol_pkg::ACT_DELETE,   16'sd0,    32'sd0,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd0}},
    '{iol_pkg::ACT_INS_AT,   16'sd1,    32'sd5,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd0}},
    '{iol_pkg::ACT_INS_AT,   16'sh8000, 32'sh0000_0011, 1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_DONE,  13'd1}},
    '{iol_pkg::ACT_APPEND,   16'sd0,    32'sh7fff_ffff, 1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_DONE,  13'd2}},
    '{iol_pkg::ACT_INS_HEAD, 16'sh7fff, 32'sh8000_0000, 1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_DONE,  13'd3}},
    '{iol_pkg::ACT_READ,     16'sd0,    32'sd0,         1'b0, '0},
    '{iol_pkg::ACT_READ,     16'sd2,    32'sd0,         1'b0, '0},
    '{iol_pkg::ACT_READ,     16'sd3,    32'sd0,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd3}},
    '{iol_pkg::ACT_READ,     16'sh7fff, 32'sd0,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd3}},
    '{iol_pkg::ACT_INS_AT,   16'sd3,    32'shffff_ffff, 1'b0, '0},
    '{iol_pkg::ACT_INS_AT,   16'sd2,    32'sh5555_aaaa, 1'b0, '0},
    '{iol_pkg::ACT_DELETE,   16'sh8000, 32'sd0,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd5}},
    '{iol_pkg::ACT_DELETE,   16'sd5,    32'sd0,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd5}},
    '{ACT_RSVD5,             16'sd0,    32'sh1234_5678, 1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_DONE,  13'd5}},
    '{ACT_RSVD7,             16'shffff, 32'shffff_ffff, 1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_DONE,  13'd5}},
    '{iol_pkg::ACT_DELETE,   16'sd0,    32'sd0,         1'b0, '0},
    '{iol_pkg::ACT_DELETE,   16'sd3,    32'sd0,         1'b0, '0},
    '{iol_pkg::ACT_READ,     16'sd1,    32'sd0,         1'b0, '0}
  };

  // Full list: every insert refused, range test ahead of the full test
  step_row_t full_rows [8] = '{
    '{iol_pkg::ACT_INS_HEAD, 16'sd0,    32'sd1,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_FULL,  13'd64}},
    '{iol_pkg::ACT_APPEND,   16'sd0,    32'sd2,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_FULL,  13'd64}},
    '{iol_pkg::ACT_INS_AT,   16'sd0,    32'sd3,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_FULL,  13'd64}},
    '{iol_pkg::ACT_INS_AT,   16'sd64,   32'sd4,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_FULL,  13'd64}},
    '{iol_pkg::ACT_INS_AT,   16'sd65,   32'sd5,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_RANGE, 13'd64}},
    '{iol_pkg::ACT_INS_AT,   -16'sd5,   32'sd6,         1'b1,
      '{iol_pkg::RD_NONE, iol_pkg::ST_FULL,  13'd64}},
    '{iol_pkg::ACT_READ,     16'sd63,   32'sd0,         1'b0, '0},
    '{iol_pkg::ACT_DELETE,   16'sd63,   32'sd0,         1'b0, '0}
  };

  indexed_ordered_list #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one action to the list model and return the reply it should produce
  function automatic reply_t apply_list_action(
      input logic [iol_pkg::ACTION_W-1:0] act,
      input logic signed [iol_pkg::POS_W-1:0] pos,
      input logic signed [iol_pkg::DATA_W-1:0] val);
    reply_t r;
    int     p;
    int     slot;
    bit     full;
    r.rd  = iol_pkg::RD_NONE;
    r.st  = iol_pkg::ST_DONE;
    p     = pos;
    slot  = -1;
    full  = list_len >= CAPACITY;
    case (act)
      iol_pkg::ACT_READ: begin
        if (p < 0 || p >= int'(list_len)) r.st = iol_pkg::ST_RANGE;
        else r.rd = list_words[p];
      end
      iol_pkg::ACT_INS_HEAD: begin
        if (full) r.st = iol_pkg::ST_FULL;
        else slot = 0;
      end
      iol_pkg::ACT_APPEND: begin
        if (full) r.st = iol_pkg::ST_FULL;
        else slot = int'(list_len);
      end
      iol_pkg::ACT_INS_AT: begin
        if (p > int'(list_len)) r.st = iol_pkg::ST_RANGE;
        else if (full) r.st = iol_pkg::ST_FULL;
        else slot = (p < 0) ? 0 : p;
      end
      iol_pkg::ACT_DELETE: begin
        if (p < 0 || p >= int'(list_len)) begin
          r.st = iol_pkg::ST_RANGE;
        end else begin
          for (int i = p; i + 1 < int'(list_len); i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      default: ;
    endcase
    // shift the tail up one place and drop the new word in
    if (slot >= 0) begin
      for (int i = int'(list_len); i > slot; i--) list_words[i] = list_words[i - 1];
      list_words[slot] = val;
      list_len++;
    end
    r.cnt = iol_pkg::COUNT_W'(list_len);
    return r;
  endfunction

  // Random action biased toward growing or shrinking the list
  function automatic step_row_t random_row(input bit growing);
    step_row_t   r;
    int unsigned roll;
    r       = '0;
    roll    = $urandom_range(0, 99);
    if (roll < 25) begin
      r.act = iol_pkg::ACT_READ;
    end else if (roll < 30) begin
      r.act = ACT_RSVD5 + iol_pkg::ACTION_W'($urandom_range(0, 2));
    end else if (growing ? roll < 85 : roll < 45) begin
      case ($urandom_range(0, 2))
        0:       r.act = iol_pkg::ACT_INS_HEAD;
        1:       r.act = iol_pkg::ACT_APPEND;
        default: r.act = iol_pkg::ACT_INS_AT;
      endcase
    end else begin
      r.act = iol_pkg::ACT_DELETE;
    end
    // mostly positions around the live range, sometimes any 16-bit value
    if ($urandom_range(0, 9) < 8) begin
      r.pos = iol_pkg::POS_W'(int'($urandom_range(0, list_len + 1)) - 1);
    end else begin
      r.pos = iol_pkg::POS_W'($urandom);
    end
    r.val = $urandom;
    return r;
  endfunction

  // Wait a gap (none when steady), hold the command until the transfer, record the expected reply
  task automatic issue_action(input step_row_t row);
    int unsigned gap;
    reply_t      predicted;
    gap = steady_feed ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= row.act;
    position_i <= row.pos;
    value_i    <= row.val;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = apply_list_action(row.act, row.pos, row.val);
    awaited_q.push_back(row.typed ? row.reply : predicted);
  endtask

  task automatic check_reply(input logic signed [iol_pkg::DATA_W-1:0] rd,
                             input logic [iol_pkg::STATUS_W-1:0] st,
                             input logic [iol_pkg::COUNT_W-1:0] cnt);
    reply_t want;
    if (awaited_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result: rd=%0d st=%0d cnt=%0d", rd, st, cnt);
    end else begin
      want = awaited_q.pop_front();
      if (rd !== want.rd || st !== want.st || cnt !== want.cnt) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result mismatch: expected rd=%0d st=%0d cnt=%0d, got rd=%0d st=%0d cnt=%0d",
                   want.rd, want.st, want.cnt, rd, st, cnt);
      end
    end
  endtask

  // Result side: one transfer per cycle with done_o high
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) check_reply(read_value_o, status_o, count_o);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_indexed_ordered_list failed");
      $finish;
    end
  end

  initial begin
    step_row_t   row;
    int unsigned seg_left;
    bit          growing;
    seg_left = 0;
    growing  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[i]) issue_action(opening_rows[i]);

    // fill to capacity with random words
    while (list_len < CAPACITY) begin
      row     = '0;
      row.act = iol_pkg::ACT_APPEND;
      row.pos = iol_pkg::POS_W'($urandom);
      row.val = $urandom;
      issue_action(row);
    end
    foreach (full_rows[i]) issue_action(full_rows[i]);

    // random phases alternate between filling and draining the list
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (seg_left == 0) begin
        growing     = ~growing;
        seg_left    = $urandom_range(50, 150);
        steady_feed = ($urandom_range(0, 3) == 0);
      end
      issue_action(random_row(growing));
      seg_left--;
    end
    start <= 1'b0;

    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("tb_indexed_ordered_list passed");
    else $display("tb_indexed_ordered_list failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/iol_pkg.sv
hdl/iol_cell.sv
hdl/indexed_ordered_list.sv
verif/tb_indexed_ordered_list.sv
